// ===== design/slds_pkg.sv =====
// shared types and widths for the skew line distance pipeline
// used by slds_div, slds_sqrt and skew_line_distance_3d
`default_nettype none

package slds_pkg;

    localparam int COORD_W    = 16;
    localparam int SQ_W       = 64;   // |n|^2
    localparam int NUMSQ_W    = 100;  // (n.d)^2
    localparam int FRAC_W     = 32;   // 2^32 scale on the radicand
    localparam int DIV_STEPS  = 66;   // quotient bits of (n.d)^2 * 2^32 / |n|^2
    localparam int SQRT_STEPS = 33;   // root bits, Q17.16 distance
    localparam int DIST_W     = 33;

    // control that rides along with each beat through the pipeline
    typedef struct packed {
        logic valid;
        logic parallel;
    } slds_tag_t;

endpackage

`default_nettype wire

// ===== design/slds_div.sv =====
// restoring divider, one quotient bit per register stage
// depends on slds_pkg
`default_nettype none

module slds_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire slds_pkg::slds_tag_t          in_tag,
    input  wire logic [slds_pkg::NUMSQ_W-1:0] in_numsq,
    input  wire logic [slds_pkg::SQ_W-1:0]    in_sq,
    output slds_pkg::slds_tag_t               out_tag,
    output logic [slds_pkg::DIV_STEPS-1:0]    out_quo
);
    import slds_pkg::*;

    localparam int LOW_W = DIV_STEPS;

    slds_tag_t          tag_reg [DIV_STEPS];
    logic [SQ_W-1:0]    rem_reg [DIV_STEPS];
    logic [LOW_W-1:0]   low_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] quo_reg [DIV_STEPS];
    logic [SQ_W-1:0]    sq_reg  [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        slds_tag_t          tag_in;
        logic [SQ_W-1:0]    rem_in;
        logic [LOW_W-1:0]   low_in;
        logic [DIV_STEPS-1:0] quo_in;
        logic [SQ_W-1:0]    sq_in;
        logic [SQ_W:0]      trial;
        logic               ge;
        logic [SQ_W-1:0]    rem_next;

        if (k == 0) begin : g_first
            // top dividend bits sit below the divisor for any nonzero divisor
            assign tag_in = in_tag;
            assign rem_in = in_numsq[LOW_W+SQ_W-FRAC_W-1:LOW_W-FRAC_W];
            assign low_in = {in_numsq[LOW_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
            assign quo_in = '0;
            assign sq_in  = in_sq;
        end else begin : g_rest
            assign tag_in = tag_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign sq_in  = sq_reg[k-1];
        end

        always_comb
        begin
            trial    = {rem_in, low_in[LOW_W-1]};
            ge       = trial >= {1'b0, sq_in};
            rem_next = ge ? SQ_W'(trial - {1'b0, sq_in}) : trial[SQ_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                tag_reg[k] <= '0;
            end else if (en) begin
                tag_reg[k] <= tag_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en) begin
                rem_reg[k] <= rem_next;
                low_reg[k] <= {low_in[LOW_W-2:0], 1'b0};
                quo_reg[k] <= {quo_in[DIV_STEPS-2:0], ge};
                sq_reg[k]  <= sq_in;
            end
        end
    end

    assign out_tag = tag_reg[DIV_STEPS-1];
    assign out_quo = quo_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== design/slds_sqrt.sv =====
// integer square root, one root bit per register stage
// depends on slds_pkg
`default_nettype none

module slds_sqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire slds_pkg::slds_tag_t           in_tag,
    input  wire logic [slds_pkg::DIV_STEPS-1:0] in_rad,
    output slds_pkg::slds_tag_t                out_tag,
    output logic [slds_pkg::SQRT_STEPS-1:0]    out_root
);
    import slds_pkg::*;

    localparam int RAD_W = DIV_STEPS;
    localparam int TRY_W = RAD_W + 2;

    slds_tag_t             tag_reg  [SQRT_STEPS];
    logic [RAD_W-1:0]      rem_reg  [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] root_reg [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam int B = SQRT_STEPS - 1 - k;

        slds_tag_t             tag_in;
        logic [RAD_W-1:0]      rem_in;
        logic [SQRT_STEPS-1:0] root_in;
        logic [TRY_W-1:0]      trial;
        logic                  ge;

        if (k == 0) begin : g_first
            assign tag_in  = in_tag;
            assign rem_in  = in_rad;
            assign root_in = '0;
        end else begin : g_rest
            assign tag_in  = tag_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // (root + 2^b)^2 - root^2
        always_comb
        begin
            trial = (TRY_W'(root_in) << (B + 1)) + (TRY_W'(1) << (2 * B));
            ge    = TRY_W'(rem_in) >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                tag_reg[k] <= '0;
            end else if (en) begin
                tag_reg[k] <= tag_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en) begin
                rem_reg[k]  <= ge ? RAD_W'(TRY_W'(rem_in) - trial) : rem_in;
                root_reg[k] <= ge ? (root_in | (SQRT_STEPS'(1) << B)) : root_in;
            end
        end
    end

    assign out_tag  = tag_reg[SQRT_STEPS-1];
    assign out_root = root_reg[SQRT_STEPS-1];

endmodule

`default_nettype wire

// ===== design/skew_line_distance_3d.sv =====
// top level: front arithmetic, divider and root pipelines, output skid
// depends on slds_pkg, slds_div, slds_sqrt
`default_nettype none

// Distance between two 3D lines, given as point and direction, as unsigned Q17.16
// truncated toward zero, with a parallel flag when the direction cross product is
// zero. Fully pipelined: one beat per clock in and out while the skid stage is
// empty. Stages: front products and sums, 66 divider stages, 33 root stages and
// one output register. s_tready is low whenever a beat waits in the skid stage,
// which fills only when the output holds a beat and m_tready is low.

module skew_line_distance_3d (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // a_point_x, a_point_y, a_point_z, a_dir_x, a_dir_y, a_dir_z,
    // b_point_x, b_point_y, b_point_z, b_dir_x, b_dir_y, b_dir_z
    input  wire logic [191:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // distance [32:0], zero fill above
    output logic [39:0]       m_tdata,
    // parallel
    output logic              m_tuser
);
    import slds_pkg::*;

    localparam int FRONT = 7;

    logic en;
    logic signed [15:0] apx, apy, apz, adx, ady, adz, bpx, bpy, bpz, bdx, bdy, bdz;

    assign apx = s_tdata[15:0];
    assign apy = s_tdata[31:16];
    assign apz = s_tdata[47:32];
    assign adx = s_tdata[63:48];
    assign ady = s_tdata[79:64];
    assign adz = s_tdata[95:80];
    assign bpx = s_tdata[111:96];
    assign bpy = s_tdata[127:112];
    assign bpz = s_tdata[143:128];
    assign bdx = s_tdata[159:144];
    assign bdy = s_tdata[175:160];
    assign bdz = s_tdata[191:176];

    logic [FRONT-1:0] fv_reg;

    // stage 1: point difference, direction products
    logic signed [16:0] dx1_reg, dy1_reg, dz1_reg;
    logic signed [31:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    // stage 2: cross product
    logic signed [16:0] dx2_reg, dy2_reg, dz2_reg;
    logic signed [32:0] nx_reg, ny_reg, nz_reg;
    // stage 3: dot terms, magnitudes
    logic signed [49:0] tx_reg, ty_reg, tz_reg;
    logic [31:0]        mx_reg, my_reg, mz_reg;
    // stage 4: dot sum, squares
    logic signed [51:0] dot_reg;
    logic [SQ_W-1:0]    qx_reg, qy_reg, qz_reg;
    // stage 5: |dot| split, |n|^2
    logic [24:0]        hi_reg, lo_reg;
    logic [SQ_W-1:0]    sq5_reg;
    // stage 6: partial products
    logic [49:0]        hh_reg, hl_reg, ll_reg;
    logic [SQ_W-1:0]    sq6_reg;
    logic               par6_reg;
    // stage 7: (n.d)^2
    logic [NUMSQ_W-1:0] numsq_reg;
    logic [SQ_W-1:0]    sq7_reg;
    logic               par7_reg;

    logic [49:0] num5;
    logic signed [51:0] dot_abs_src;

    assign dot_abs_src = dot_reg < 0 ? -dot_reg : dot_reg;
    assign num5        = dot_abs_src[49:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fv_reg <= '0;
        end else if (en) begin
            fv_reg <= {fv_reg[FRONT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            dx1_reg <= 17'(bpx) - 17'(apx);
            dy1_reg <= 17'(bpy) - 17'(apy);
            dz1_reg <= 17'(bpz) - 17'(apz);
            p0_reg  <= 32'(ady) * 32'(bdz);
            p1_reg  <= 32'(adz) * 32'(bdy);
            p2_reg  <= 32'(adz) * 32'(bdx);
            p3_reg  <= 32'(adx) * 32'(bdz);
            p4_reg  <= 32'(adx) * 32'(bdy);
            p5_reg  <= 32'(ady) * 32'(bdx);

            dx2_reg <= dx1_reg;
            dy2_reg <= dy1_reg;
            dz2_reg <= dz1_reg;
            nx_reg  <= 33'(p0_reg) - 33'(p1_reg);
            ny_reg  <= 33'(p2_reg) - 33'(p3_reg);
            nz_reg  <= 33'(p4_reg) - 33'(p5_reg);

            tx_reg  <= 50'(nx_reg) * 50'(dx2_reg);
            ty_reg  <= 50'(ny_reg) * 50'(dy2_reg);
            tz_reg  <= 50'(nz_reg) * 50'(dz2_reg);
            mx_reg  <= nx_reg < 0 ? 32'(-nx_reg) : nx_reg[31:0];
            my_reg  <= ny_reg < 0 ? 32'(-ny_reg) : ny_reg[31:0];
            mz_reg  <= nz_reg < 0 ? 32'(-nz_reg) : nz_reg[31:0];

            dot_reg <= 52'(tx_reg) + 52'(ty_reg) + 52'(tz_reg);
            qx_reg  <= SQ_W'(mx_reg) * SQ_W'(mx_reg);
            qy_reg  <= SQ_W'(my_reg) * SQ_W'(my_reg);
            qz_reg  <= SQ_W'(mz_reg) * SQ_W'(mz_reg);

            hi_reg  <= num5[49:25];
            lo_reg  <= num5[24:0];
            sq5_reg <= qx_reg + qy_reg + qz_reg;

            hh_reg   <= 50'(hi_reg) * 50'(hi_reg);
            hl_reg   <= 50'(hi_reg) * 50'(lo_reg);
            ll_reg   <= 50'(lo_reg) * 50'(lo_reg);
            sq6_reg  <= sq5_reg;
            par6_reg <= sq5_reg == '0;

            numsq_reg <= (NUMSQ_W'(hh_reg) << 50) + (NUMSQ_W'(hl_reg) << 26)
                       + NUMSQ_W'(ll_reg);
            sq7_reg   <= sq6_reg;
            par7_reg  <= par6_reg;
        end
    end

    slds_tag_t             div_tag_in, div_tag_out, rt_tag_out;
    logic [DIV_STEPS-1:0]  quo;
    logic [SQRT_STEPS-1:0] root;

    assign div_tag_in.valid    = fv_reg[FRONT-1];
    assign div_tag_in.parallel = par7_reg;

    slds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_tag   (div_tag_in),
        .in_numsq (numsq_reg),
        .in_sq    (sq7_reg),
        .out_tag  (div_tag_out),
        .out_quo  (quo)
    );

    slds_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_tag   (div_tag_out),
        .in_rad   (quo),
        .out_tag  (rt_tag_out),
        .out_root (root)
    );

    // output register plus skid stage
    logic              out_vld_reg, out_vld_next, skid_vld_reg, skid_vld_next;
    logic [DIST_W-1:0] out_dist_reg, out_dist_next, skid_dist_reg, skid_dist_next;
    logic              out_par_reg, out_par_next, skid_par_reg, skid_par_next;
    logic              out_free;
    logic [DIST_W-1:0] new_dist;

    assign en       = !skid_vld_reg;
    assign out_free = !out_vld_reg || m_tready;
    assign new_dist = rt_tag_out.parallel ? '0 : root;

    always_comb
    begin
        out_vld_next   = out_vld_reg && !m_tready;
        out_dist_next  = out_dist_reg;
        out_par_next   = out_par_reg;
        skid_vld_next  = skid_vld_reg;
        skid_dist_next = skid_dist_reg;
        skid_par_next  = skid_par_reg;
        if (skid_vld_reg) begin
            if (out_free) begin
                out_vld_next  = 1'b1;
                out_dist_next = skid_dist_reg;
                out_par_next  = skid_par_reg;
                skid_vld_next = 1'b0;
            end
        end else if (rt_tag_out.valid) begin
            if (out_free) begin
                out_vld_next  = 1'b1;
                out_dist_next = new_dist;
                out_par_next  = rt_tag_out.parallel;
            end else begin
                skid_vld_next  = 1'b1;
                skid_dist_next = new_dist;
                skid_par_next  = rt_tag_out.parallel;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_dist_reg  <= out_dist_next;
        out_par_reg   <= out_par_next;
        skid_dist_reg <= skid_dist_next;
        skid_par_reg  <= skid_par_next;
    end

    assign s_tready = en;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'b0, out_dist_reg};
    assign m_tuser  = out_par_reg;

    a_par_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_par_reg |-> out_dist_reg == '0)
        else $error("parallel beat with nonzero distance");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid stage holds a beat while output is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !m_tready))
        else $error("skid filled while output could take the beat");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// testbench for skew_line_distance_3d: random and directed line pairs, exact predictor
// depends on slds_pkg and the skew_line_distance_3d rtl
`timescale 1ns / 1ps

module tb_top;
    import slds_pkg::*;

    localparam int LATENCY = 107;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              parallel;
    } dist_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic         m_tuser;

    logic [191:0] pending_lines[$];
    dist_result_t expected_dist[$];
    int           mismatches;
    bit           stim_done;
    int           src_gap;
    int           snk_gap;
    // handshake seen at the last rising edge
    logic         s_tready_seen;

    skew_line_distance_3d u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // largest q with q*q*|n|^2 <= (n.d)^2 * 2^32
    function automatic dist_result_t line_distance(logic [191:0] beat);
        logic signed [16:0] px, py, pz;
        logic signed [15:0] ax, ay, az, bx, by, bz;
        logic signed [65:0] nx, ny, nz;
        logic signed [65:0] dot;
        logic [65:0]  num;
        logic [65:0]  sq;
        logic [159:0] rhs;
        logic [159:0] lhs;
        logic [32:0]  q;
        logic [32:0]  t;
        dist_result_t res;
        px = $signed(beat[111:96]) - $signed(beat[15:0]);
        py = $signed(beat[127:112]) - $signed(beat[31:16]);
        pz = $signed(beat[143:128]) - $signed(beat[47:32]);
        ax = beat[63:48];
        ay = beat[79:64];
        az = beat[95:80];
        bx = beat[159:144];
        by = beat[175:160];
        bz = beat[191:176];
        nx = ay * bz - az * by;
        ny = az * bx - ax * bz;
        nz = ax * by - ay * bx;
        dot = nx * px + ny * py + nz * pz;
        num = dot[65] ? -dot : dot;
        sq = nx * nx + ny * ny + nz * nz;
        res.distance = '0;
        res.parallel = 1'b0;
        if (sq == 0)
        begin
            res.parallel = 1'b1;
            return res;
        end
        rhs = (160'(num) * 160'(num)) << 32;
        q = '0;
        for (int b = 32; b >= 0; b--)
        begin
            t = q | (33'd1 << b);
            lhs = 160'(t) * 160'(t) * 160'(sq);
            if (lhs <= rhs)
                q = t;
        end
        res.distance = q;
        return res;
    endfunction

    function automatic logic [191:0] pack_lines(logic signed [15:0] f[12]);
        logic [191:0] v;
        for (int i = 0; i < 12; i++)
            v[i*16 +: 16] = f[i];
        return v;
    endfunction

    function automatic void queue_line(logic [191:0] v);
        pending_lines = {pending_lines, v};
    endfunction

    function automatic logic [15:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h8000;
        else if (r == 1)
            return 16'h7fff;
        else if (r < 5)
            return 16'($signed($urandom_range(0, 40)) - 20);
        else
            return 16'($urandom);
    endfunction

    initial
    begin
        logic signed [15:0] f[12];
        int k;
        // directed: extremes, parallel, null and perpendicular directions
        for (int i = 0; i < 12; i++) f[i] = 16'sh0000;
        queue_line(pack_lines(f));
        for (int i = 0; i < 12; i++) f[i] = 16'sh7fff;
        queue_line(pack_lines(f));
        for (int i = 0; i < 12; i++) f[i] = -16'sh8000;
        queue_line(pack_lines(f));
        for (int i = 0; i < 12; i++) f[i] = i[0] ? -16'sh8000 : 16'sh7fff;
        queue_line(pack_lines(f));
        for (int i = 0; i < 12; i++) f[i] = 16'sh0000;
        f[0] = -16'sh8000; f[1] = -16'sh8000; f[2] = -16'sh8000;
        f[3] = 16'sh0001; f[10] = 16'sh0001;
        f[6] = 16'sh7fff; f[7] = 16'sh7fff; f[8] = 16'sh7fff;
        queue_line(pack_lines(f));
        f[3] = -16'sh8000; f[4] = 0; f[5] = 0;
        f[9] = 0; f[10] = -16'sh8000; f[11] = 0;
        queue_line(pack_lines(f));
        f[3] = 16'sh7fff; f[4] = -16'sh8000; f[5] = 16'sh7fff;
        f[9] = -16'sh8000; f[10] = 16'sh7fff; f[11] = -16'sh8000;
        queue_line(pack_lines(f));
        // parallel: b_dir = 2 * a_dir, and a null direction
        for (int i = 0; i < 12; i++) f[i] = 16'($signed($urandom_range(0, 2000)) - 1000);
        f[9] = f[3] * 2; f[10] = f[4] * 2; f[11] = f[5] * 2;
        queue_line(pack_lines(f));
        f[3] = 0; f[4] = 0; f[5] = 0;
        queue_line(pack_lines(f));
        f[9] = -16'sh8000; f[10] = -16'sh8000; f[11] = -16'sh8000;
        f[3] = -16'sh8000; f[4] = -16'sh8000; f[5] = -16'sh8000;
        queue_line(pack_lines(f));
        // intersecting lines: same point
        for (int i = 0; i < 12; i++) f[i] = 16'($urandom);
        f[6] = f[0]; f[7] = f[1]; f[8] = f[2];
        queue_line(pack_lines(f));
        for (int n = 0; n < 500; n++)
        begin
            for (int i = 0; i < 12; i++) f[i] = rand_coord();
            k = $urandom_range(0, 9);
            if (k == 0)
            begin
                // small random multiples per component; parallel when all components are set equal
                f[9] = f[3] * 16'($signed($urandom_range(0, 4)) - 2);
                f[10] = f[4] * 16'($signed($urandom_range(0, 4)) - 2);
                f[11] = f[5] * 16'($signed($urandom_range(0, 4)) - 2);
                if ($urandom_range(0, 1))
                begin
                    f[10] = f[9]; f[11] = f[9]; f[4] = f[3]; f[5] = f[3];
                end
            end
            queue_line(pack_lines(f));
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // driver
    initial
    begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        stim_done = 1'b0;
        src_gap = 0;
        snk_gap = 0;
        mismatches = 0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || s_tready_seen)
            begin
                if (src_gap > 0)
                begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_lines.size() > 0)
                begin
                    s_tdata <= pending_lines.pop_front();
                    s_tvalid <= 1'b1;
                    src_gap <= gap_len();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
            if (snk_gap > 0)
            begin
                snk_gap <= snk_gap - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                snk_gap <= gap_len();
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_tready_seen <= 1'b0;
        else
            s_tready_seen <= s_tvalid && s_tready;
    end

    // monitor
    always @(posedge clk)
    begin
        dist_result_t exp_r;
        if (rst_n && s_tvalid && s_tready)
            expected_dist = {expected_dist, line_distance(s_tdata)};
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_dist.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected beat: distance %h parallel %b", m_tdata, m_tuser);
            end
            else
            begin
                exp_r = expected_dist.pop_front();
                if (m_tdata !== {7'd0, exp_r.distance} || m_tuser !== exp_r.parallel)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch: distance exp %h got %h, parallel exp %b got %b",
                                 exp_r.distance, m_tdata, exp_r.parallel, m_tuser);
                end
            end
        end
    end

    initial
    begin
        wait (stim_done);
        wait (expected_dist.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        if (mismatches == 0 && expected_dist.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
